>>> design/mscbs_pkg.sv
// ----------------------------------------------------------------------------
// MPEG start code block splitter package
// Shared widths, codes, event and result types for the block splitter.
// ----------------------------------------------------------------------------
package mscbs_pkg;

    // Width of the byte counter and of all offsets kept inside the block.
    localparam int OFFSET_BITS = 40;
    // Width of the offset and length fields of a result.
    localparam int OUT_LEN_W   = 40;
    // Width of a timestamp.
    localparam int TS_W        = 63;
    // Depth of the event queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Start code history constants.
    localparam logic [23:0] HIST_RESET      = 24'hFFFFFF;
    localparam logic [23:0] START_PREFIX    = 24'h000001;
    localparam logic [23:0] HIST_AFTER_CODE = 24'hFFFF00;
    localparam logic [OFFSET_BITS-1:0] PREFIX_LEN = OFFSET_BITS'(3);

    // Code type bytes that follow a start code prefix.
    localparam logic [7:0] CODE_SEQ = 8'hB3;
    localparam logic [7:0] CODE_GOP = 8'hB8;
    localparam logic [7:0] CODE_PIC = 8'h00;

    // Request codes carried in the input tuser.
    typedef enum logic [1:0] {
        REQ_DATA  = 2'd0,
        REQ_EOS   = 2'd1,
        REQ_FLUSH = 2'd2
    } req_t;

    // Kind of the code that opened a block.
    typedef enum logic [1:0] {
        KIND_SEQ = 2'd0,
        KIND_GOP = 2'd1,
        KIND_PIC = 2'd2
    } kind_t;

    // Last sync code seen.
    typedef enum logic [1:0] {
        SYNC_NONE = 2'd0,
        SYNC_SEQ  = 2'd1,
        SYNC_GOP  = 2'd2,
        SYNC_PIC  = 2'd3
    } sync_t;

    // Events passed from the front to the back.
    typedef enum logic [1:0] {
        EV_BEGIN    = 2'd0,
        EV_JOIN_PIC = 2'd1,
        EV_EOS      = 2'd2,
        EV_FLUSH    = 2'd3
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t               ev;
        kind_t                  kind;
        logic [OFFSET_BITS-1:0] pos;
        logic [TS_W-1:0]        ts;
        logic                   ts_ok;
    } blk_event_t;

    typedef struct packed {
        logic [OUT_LEN_W-1:0] offset;
        logic [OUT_LEN_W-1:0] length;
        kind_t                first_kind;
        logic                 has_seq;
        logic                 has_gop;
        logic                 has_pic;
        logic [TS_W-1:0]      ts;
        logic                 ts_ok;
    } blk_result_t;

endpackage

>>> design/mscbs_front.sv
// ----------------------------------------------------------------------------
// Block splitter front end
// Scans the byte stream for start codes, tracks buffer timestamps and turns
// each accepted request into at most one block event for the back end.
// ----------------------------------------------------------------------------
module mscbs_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [1:0]                        req_type,
    input  logic [7:0]                        data_byte,
    input  logic                              buffer_start,
    input  logic [mscbs_pkg::TS_W-1:0]        buffer_ts,
    input  logic                              buffer_ts_valid,
    output logic                              ev_valid,
    output mscbs_pkg::blk_event_t             ev
);
    import mscbs_pkg::*;

    logic [23:0]            hist_reg, hist_next;
    logic [OFFSET_BITS-1:0] count_reg, count_next;
    logic [OFFSET_BITS-1:0] base_reg, base_next;
    logic [TS_W-1:0]        cur_ts_reg, cur_ts_next;
    logic                   cur_ok_reg, cur_ok_next;
    logic [TS_W-1:0]        prev_ts_reg, prev_ts_next;
    logic                   prev_ok_reg, prev_ok_next;
    sync_t                  sync_reg, sync_next;

    logic [OFFSET_BITS-1:0] code_pos;
    logic                   cur_fresh;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg    <= HIST_RESET;
            count_reg   <= '0;
            base_reg    <= '0;
            cur_ts_reg  <= '0;
            cur_ok_reg  <= 1'b0;
            prev_ts_reg <= '0;
            prev_ok_reg <= 1'b0;
            sync_reg    <= SYNC_NONE;
        end
        else
        begin
            hist_reg    <= hist_next;
            count_reg   <= count_next;
            base_reg    <= base_next;
            cur_ts_reg  <= cur_ts_next;
            cur_ok_reg  <= cur_ok_next;
            prev_ts_reg <= prev_ts_next;
            prev_ok_reg <= prev_ok_next;
            sync_reg    <= sync_next;
        end
    end

    // Request handling: buffer bookkeeping, start code detection and events.
    always_comb
    begin
        hist_next    = hist_reg;
        count_next   = count_reg;
        base_next    = base_reg;
        cur_ts_next  = cur_ts_reg;
        cur_ok_next  = cur_ok_reg;
        prev_ts_next = prev_ts_reg;
        prev_ok_next = prev_ok_reg;
        sync_next    = sync_reg;
        ev_valid     = 1'b0;
        ev.ev        = EV_BEGIN;
        ev.kind      = KIND_SEQ;
        ev.pos       = count_reg;
        ev.ts        = '0;
        ev.ts_ok     = 1'b0;
        code_pos     = count_reg - PREFIX_LEN;
        cur_fresh    = 1'b0;

        if (accept)
        begin
            case (req_type)
                REQ_FLUSH:
                begin
                    hist_next    = HIST_RESET;
                    count_next   = '0;
                    base_next    = '0;
                    cur_ts_next  = '0;
                    cur_ok_next  = 1'b0;
                    prev_ts_next = '0;
                    prev_ok_next = 1'b0;
                    sync_next    = SYNC_NONE;
                    ev_valid     = 1'b1;
                    ev.ev        = EV_FLUSH;
                end
                REQ_EOS:
                begin
                    ev_valid = (count_reg != '0);
                    ev.ev    = EV_EOS;
                end
                REQ_DATA:
                begin
                    // A new buffer shifts the current timestamp to previous.
                    if (buffer_start)
                    begin
                        if (cur_ok_reg)
                        begin
                            prev_ts_next = cur_ts_reg;
                            prev_ok_next = 1'b1;
                        end
                        cur_ok_next = buffer_ts_valid;
                        cur_ts_next = buffer_ts_valid ? buffer_ts : '0;
                        base_next   = count_reg;
                    end

                    ev.pos = code_pos;
                    if (hist_reg == START_PREFIX)
                    begin
                        hist_next = HIST_AFTER_CODE | {16'h0000, data_byte};
                        if (data_byte == CODE_SEQ)
                        begin
                            ev_valid  = 1'b1;
                            ev.kind   = KIND_SEQ;
                            sync_next = SYNC_SEQ;
                        end
                        else if (data_byte == CODE_GOP)
                        begin
                            ev_valid  = 1'b1;
                            ev.kind   = KIND_GOP;
                            sync_next = SYNC_GOP;
                        end
                        else if (data_byte == CODE_PIC)
                        begin
                            ev_valid  = 1'b1;
                            ev.kind   = KIND_PIC;
                            ev.ev     = (sync_reg == SYNC_GOP) ? EV_JOIN_PIC : EV_BEGIN;
                            sync_next = SYNC_PIC;
                            // The picture takes the timestamp of the buffer where
                            // its code began, else that of the buffer before.
                            cur_fresh = (code_pos >= base_next) && cur_ok_next;
                            if (cur_fresh)
                            begin
                                ev.ts       = cur_ts_next;
                                ev.ts_ok    = 1'b1;
                                cur_ts_next = '0;
                                cur_ok_next = 1'b0;
                            end
                            else
                            begin
                                ev.ts    = prev_ok_next ? prev_ts_next : '0;
                                ev.ts_ok = prev_ok_next;
                            end
                            prev_ts_next = '0;
                            prev_ok_next = 1'b0;
                        end
                    end
                    else
                    begin
                        hist_next = {hist_reg[15:0], data_byte};
                    end

                    // The byte counter saturates.
                    if (count_reg != {OFFSET_BITS{1'b1}})
                    begin
                        count_next = count_reg + OFFSET_BITS'(1);
                    end
                end
                default:
                begin
                    ev_valid = 1'b0;
                end
            endcase
        end
    end

endmodule

>>> design/mscbs_fifo.sv
// ----------------------------------------------------------------------------
// Block splitter event queue
// A short first-in first-out queue of block events between front and back.
// ----------------------------------------------------------------------------
module mscbs_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mscbs_pkg::blk_event_t push_data,
    input  logic                  pop,
    output mscbs_pkg::blk_event_t pop_data,
    output logic                  full,
    output logic                  empty
);
    import mscbs_pkg::*;

    blk_event_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/mscbs_back.sv
// ----------------------------------------------------------------------------
// Block splitter back end
// Keeps the open block, applies queued events to it and holds each
// completed block in the output register until it is taken.
// ----------------------------------------------------------------------------
module mscbs_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  mscbs_pkg::blk_event_t   q_data,
    output logic                    q_pop,
    output logic                    res_valid,
    input  logic                    res_ready,
    output mscbs_pkg::blk_result_t  res
);
    import mscbs_pkg::*;

    logic                   open_reg, open_next;
    logic [OFFSET_BITS-1:0] open_ofs_reg, open_ofs_next;
    kind_t                  open_kind_reg, open_kind_next;
    logic [2:0]             open_flags_reg, open_flags_next;
    logic [TS_W-1:0]        open_ts_reg, open_ts_next;
    logic                   open_ts_ok_reg, open_ts_ok_next;
    logic                   res_valid_reg, res_valid_next;
    blk_result_t            res_reg, res_next;
    logic                   emit;
    logic [OFFSET_BITS-1:0] blk_len;

    assign q_pop     = !q_empty && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign blk_len   = q_data.pos - open_ofs_reg;

    // Event execution against the open block.
    always_comb
    begin
        open_next       = open_reg;
        open_ofs_next   = open_ofs_reg;
        open_kind_next  = open_kind_reg;
        open_flags_next = open_flags_reg;
        open_ts_next    = open_ts_reg;
        open_ts_ok_next = open_ts_ok_reg;
        emit            = 1'b0;

        if (q_pop)
        begin
            case (q_data.ev)
                EV_FLUSH:
                begin
                    open_next = 1'b0;
                end
                EV_EOS:
                begin
                    emit      = open_reg;
                    open_next = 1'b0;
                end
                EV_BEGIN:
                begin
                    emit            = open_reg;
                    open_next       = 1'b1;
                    open_ofs_next   = q_data.pos;
                    open_kind_next  = q_data.kind;
                    open_flags_next = 3'b001 << q_data.kind;
                    open_ts_next    = q_data.ts;
                    open_ts_ok_next = q_data.ts_ok;
                end
                EV_JOIN_PIC:
                begin
                    if (open_reg)
                    begin
                        open_flags_next = open_flags_reg | (3'b001 << KIND_PIC);
                        open_ts_next    = q_data.ts;
                        open_ts_ok_next = q_data.ts_ok;
                    end
                end
                default:
                begin
                    open_next = open_reg;
                end
            endcase
        end
    end

    // Output register: loaded when a block closes, cleared when taken.
    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (emit)
        begin
            res_valid_next      = 1'b1;
            res_next.offset     = OUT_LEN_W'(open_ofs_reg);
            res_next.length     = OUT_LEN_W'(blk_len);
            res_next.first_kind = open_kind_reg;
            res_next.has_seq    = open_flags_reg[KIND_SEQ];
            res_next.has_gop    = open_flags_reg[KIND_GOP];
            res_next.has_pic    = open_flags_reg[KIND_PIC];
            res_next.ts         = open_ts_ok_reg ? open_ts_reg : '0;
            res_next.ts_ok      = open_ts_ok_reg;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 1'b0;
            open_ts_ok_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            open_reg       <= open_next;
            open_ts_ok_reg <= open_ts_ok_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        open_ofs_reg   <= open_ofs_next;
        open_kind_reg  <= open_kind_next;
        open_flags_reg <= open_flags_next;
        open_ts_reg    <= open_ts_next;
        res_reg        <= res_next;
    end

endmodule

>>> design/mpeg_start_code_block_splitter_unit.sv
// ----------------------------------------------------------------------------
// MPEG start code block splitter
// Splits an MPEG video byte stream into blocks at sequence, GOP and picture
// start codes and reports each block with its offset, length and timestamp.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle (data byte, end of stream or
// flush) and keeps that rate as long as results are taken. A request that
// closes a block shows its result on the master side through the queue and
// the output register, once the events before it are applied and the output
// register is free: the front end writes the event into a two-entry queue at
// the transfer edge, and the back end applies it to the open block and loads
// the output register. Each request yields at most one result. Offsets count
// bytes since the last flush; the counter saturates, and lengths are taken
// modulo its width.
module mpeg_start_code_block_splitter_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // data_byte [7:0], buffer_ts [70:8], zero pad [71]
    input  logic [71:0]  s_tdata,
    // req_type [1:0], buffer_start [2], buffer_ts_valid [3]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // block_offset [39:0], block_length [79:40], has_sequence [80],
    // has_gop [81], has_picture [82], block_ts [145:83],
    // block_ts_valid [146], zero pad [151:147]
    output logic [151:0] m_tdata,
    // first_kind [1:0]
    output logic [1:0]   m_tuser
);
    import mscbs_pkg::*;

    logic        in_xfer;
    logic        ev_valid;
    blk_event_t  ev;
    blk_event_t  q_data;
    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;
    blk_result_t res;

    assign s_tready = !q_full;
    assign in_xfer  = s_tvalid && s_tready;
    assign q_push   = ev_valid;

    // Front end: start code scan and timestamp tracking.
    mscbs_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_xfer),
        .req_type        (s_tuser[1:0]),
        .data_byte       (s_tdata[7:0]),
        .buffer_start    (s_tuser[2]),
        .buffer_ts       (s_tdata[70:8]),
        .buffer_ts_valid (s_tuser[3]),
        .ev_valid        (ev_valid),
        .ev              (ev)
    );

    // Event queue between the two halves.
    mscbs_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (ev),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: open block and output register.
    mscbs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Result packing.
    assign m_tdata = {5'b00000, res.ts_ok, res.ts, res.has_pic, res.has_gop, res.has_seq,
                      res.length, res.offset};
    assign m_tuser = res.first_kind;

    // An event is never written into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("event pushed into a full queue");

    // The back end never reads an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("event popped from an empty queue");

    // A new result only appears after an event was taken from the queue.
    assert property (@(posedge clk) disable iff (!rst_n) $rose(m_tvalid) |-> $past(q_pop))
        else $error("result appeared without a queued event");

endmodule
